/* src/gdme_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdme_pkg
// Shared constants, types and direction helpers for the maze explorer.
// ----------------------------------------------------------------------------
package gdme_pkg;

  localparam int MAX_ROWS  = 32;
  localparam int MAX_COLS  = 32;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int CELLS     = MAX_ROWS * MAX_COLS;
  localparam int CELL_W    = $clog2(CELLS);
  localparam int SP_W      = CELL_W + 1;
  localparam int BANKS     = 4;
  localparam int BANK_W    = 2;
  localparam int BANK_ROWS = MAX_ROWS / BANKS;
  localparam int BIDX_W    = $clog2(BANK_ROWS);
  localparam int DIRS      = 4;
  localparam int DIR_W     = 2;
  localparam int DIM_W     = 6;
  localparam int READ_W    = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

  localparam logic [READ_W-1:0] WALL_CHAR = 8'h62;
  localparam logic [DIM_W-1:0]  DIM_MIN   = 6'd2;
  localparam logic [DIM_W-1:0]  DIM_RESET = 6'd32;

  localparam int START_ROW = 1;
  localparam int START_COL = 1;

  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

  typedef logic [MAX_COLS-1:0] row_word_t;

  typedef struct packed {
    logic             cand;
    logic [ROW_W-1:0] nrow;
    logic [COL_W-1:0] ncol;
    row_word_t        wr_word;
  } lane_res_t;

  typedef struct packed {
    logic             has_move;
    logic [DIR_W-1:0] dir;
    logic             back;
    logic             push;
    logic             pop;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    row_word_t        wr_word;
  } decision_t;

  // two's complement row step of a direction
  function automatic logic [1:0] dir_drow(input logic [DIR_W-1:0] d);
    logic [1:0] s;
    case (d)
      DIR_UP:   s = 2'b11;
      DIR_DOWN: s = 2'b01;
      default:  s = 2'b00;
    endcase
    return s;
  endfunction

  // two's complement column step of a direction
  function automatic logic [1:0] dir_dcol(input logic [DIR_W-1:0] d);
    logic [1:0] s;
    case (d)
      DIR_RIGHT: s = 2'b01;
      DIR_LEFT:  s = 2'b11;
      default:   s = 2'b00;
    endcase
    return s;
  endfunction

endpackage

/* src/gdme_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdme_in_if
// Step channel: four sensed neighbour characters per word.
// ----------------------------------------------------------------------------
interface gdme_in_if;
  logic                         valid;
  logic                         ready;
  logic [gdme_pkg::READ_W-1:0]  reading_up;
  logic [gdme_pkg::READ_W-1:0]  reading_down;
  logic [gdme_pkg::READ_W-1:0]  reading_left;
  logic [gdme_pkg::READ_W-1:0]  reading_right;

  modport source (output valid, reading_up, reading_down, reading_left, reading_right,
                  input ready);
  modport sink (input valid, reading_up, reading_down, reading_left, reading_right,
                output ready);
endinterface

/* src/gdme_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdme_out_if
// Move channel: one move word per step.
// ----------------------------------------------------------------------------
interface gdme_out_if;
  logic                        valid;
  logic                        ready;
  logic                        has_move;
  logic [gdme_pkg::DIR_W-1:0]  direction;
  logic                        is_backtrack;
  logic [gdme_pkg::ROW_W-1:0]  pos_row;
  logic [gdme_pkg::COL_W-1:0]  pos_col;

  modport source (output valid, has_move, direction, is_backtrack, pos_row, pos_col,
                  input ready);
  modport sink (input valid, has_move, direction, is_backtrack, pos_row, pos_col,
                output ready);
endinterface

/* src/gdme_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gdme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/gdme_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdme_lane
// One neighbour lane: bounds, wall and visited check for a single direction.
// ----------------------------------------------------------------------------
module gdme_lane (
  input  logic [gdme_pkg::DIR_W-1:0]  dir,
  input  logic [gdme_pkg::READ_W-1:0] reading,
  input  logic [gdme_pkg::ROW_W-1:0]  cur_row,
  input  logic [gdme_pkg::COL_W-1:0]  cur_col,
  input  logic [gdme_pkg::DIM_W-1:0]  eff_h,
  input  logic [gdme_pkg::DIM_W-1:0]  eff_w,
  input  gdme_pkg::row_word_t         row_word,
  output gdme_pkg::lane_res_t         res
);
  import gdme_pkg::*;

  logic [1:0]       dr;
  logic [1:0]       dc;
  logic [ROW_W+1:0] nr_ext;
  logic [COL_W+1:0] nc_ext;
  logic             in_grid;
  logic             wall;
  logic [COL_W-1:0] nc;

  always_comb begin
    dr      = dir_drow(dir);
    dc      = dir_dcol(dir);
    nr_ext  = {2'b00, cur_row} + {{ROW_W{dr[1]}}, dr};
    nc_ext  = {2'b00, cur_col} + {{COL_W{dc[1]}}, dc};
    in_grid = (nr_ext < (ROW_W+2)'(eff_h)) && (nc_ext < (COL_W+2)'(eff_w));
    wall    = (reading == WALL_CHAR);
    nc      = nc_ext[COL_W-1:0];

    res.cand    = in_grid && !wall && !row_word[nc];
    res.nrow    = nr_ext[ROW_W-1:0];
    res.ncol    = nc;
    res.wr_word = row_word | ({{(MAX_COLS-1){1'b0}}, 1'b1} << nc);
  end

endmodule

/* src/gdme_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdme_merge
// Pick the first open lane in up, right, down, left order while the stack has room, else backtrack if it is non-empty.
// ----------------------------------------------------------------------------
module gdme_merge (
  input  gdme_pkg::lane_res_t         lane_res [gdme_pkg::DIRS],
  input  logic                        stack_ok,
  input  logic                        stack_any,
  input  logic [gdme_pkg::ROW_W-1:0]  cur_row,
  input  logic [gdme_pkg::COL_W-1:0]  cur_col,
  input  logic [gdme_pkg::ROW_W-1:0]  pop_row,
  input  logic [gdme_pkg::COL_W-1:0]  pop_col,
  output gdme_pkg::decision_t         dec
);
  import gdme_pkg::*;

  logic             found;
  logic [DIR_W-1:0] sel;
  logic [ROW_W:0]   cr_x;
  logic [ROW_W:0]   pr_x;
  logic [COL_W:0]   cc_x;
  logic [COL_W:0]   pc_x;

  always_comb begin
    found = 1'b0;
    sel   = DIR_UP;
    for (int k = DIRS - 1; k >= 0; k--) begin
      if (lane_res[k].cand) begin
        found = 1'b1;
        sel   = DIR_W'(k);
      end
    end

    cr_x = {1'b0, cur_row};
    pr_x = {1'b0, pop_row};
    cc_x = {1'b0, cur_col};
    pc_x = {1'b0, pop_col};

    dec          = '0;
    dec.row      = cur_row;
    dec.col      = cur_col;
    dec.wr_word  = lane_res[sel].wr_word;
    if (stack_ok && found) begin
      dec.has_move = 1'b1;
      dec.push     = 1'b1;
      dec.dir      = sel;
      dec.row      = lane_res[sel].nrow;
      dec.col      = lane_res[sel].ncol;
    end else if (stack_any) begin
      dec.has_move = 1'b1;
      dec.pop      = 1'b1;
      dec.back     = 1'b1;
      dec.row      = pop_row;
      dec.col      = pop_col;
      if (pr_x + 1'b1 == cr_x) begin
        dec.dir = DIR_UP;
      end else if (cr_x + 1'b1 == pr_x) begin
        dec.dir = DIR_DOWN;
      end else if (pc_x + 1'b1 == cc_x) begin
        dec.dir = DIR_LEFT;
      end else begin
        dec.dir = DIR_RIGHT;
      end
    end
  end

endmodule

/* src/grid_dfs_maze_explorer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_dfs_maze_explorer
// Depth-first maze explorer: four neighbour lanes, priority merge, banked
// visited map and return stack in RAM.
// The result word is registered when the step commits; commit waits while an
// earlier move word is still unaccepted. A new step word is taken only after
// the previous one commits, as the visited-map read then write goes through the registered-read banks.
// Reset: a clearing pass zeroes the visited banks (start cell set); steps
// are held off meanwhile, configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module grid_dfs_maze_explorer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gdme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gdme_pkg::DIM_W-1:0]     cfg_wdata,
  gdme_in_if.sink                        in_ch,
  gdme_out_if.source                     out_ch
);
  import gdme_pkg::*;

  logic [DIM_W-1:0]  grid_w_r;
  logic [DIM_W-1:0]  grid_h_r;
  logic [DIM_W-1:0]  eff_w;
  logic [DIM_W-1:0]  eff_h;

  logic [BIDX_W-1:0] clr_cnt_r;
  logic              clear_done_r;

  logic              busy_r;
  logic              commit;
  logic [READ_W-1:0] rd_up_r;
  logic [READ_W-1:0] rd_down_r;
  logic [READ_W-1:0] rd_left_r;
  logic [READ_W-1:0] rd_right_r;

  logic [ROW_W-1:0]  cur_row_r;
  logic [COL_W-1:0]  cur_col_r;
  logic [SP_W-1:0]   sp_r;

  logic              out_valid_r;
  logic              out_move_r;
  logic [DIR_W-1:0]  out_dir_r;
  logic              out_back_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;

  row_word_t         bank_rd [BANKS];
  row_word_t         lane_word [DIRS];
  logic [READ_W-1:0] lane_read [DIRS];
  logic [DIR_W-1:0]  lane_dir [DIRS];
  lane_res_t         lane_res [DIRS];
  decision_t         dec;

  logic [ROW_W-1:0]  row_m1;
  logic [ROW_W-1:0]  row_p1;
  logic [ROW_W+COL_W-1:0] stk_rd;

  // effective grid size
  always_comb begin
    eff_w = (grid_w_r < DIM_MIN) ? DIM_MIN :
            (grid_w_r > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_w_r;
    eff_h = (grid_h_r < DIM_MIN) ? DIM_MIN :
            (grid_h_r > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_h_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= DIM_RESET;
      grid_h_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_w_r <= cfg_wdata;
        CFG_GRID_HEIGHT: grid_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r    <= '0;
      clear_done_r <= 1'b0;
    end else if (!clear_done_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == BIDX_W'(BANK_ROWS - 1)) begin
        clear_done_r <= 1'b1;
      end
    end
  end

  assign in_ch.ready = clear_done_r && !busy_r;
  assign commit      = busy_r && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      rd_up_r    <= in_ch.reading_up;
      rd_down_r  <= in_ch.reading_down;
      rd_left_r  <= in_ch.reading_left;
      rd_right_r <= in_ch.reading_right;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      busy_r <= 1'b1;
    end else if (commit) begin
      busy_r <= 1'b0;
    end
  end

  // visited banks, row r lives in bank r mod 4
  assign row_m1 = cur_row_r - 1'b1;
  assign row_p1 = cur_row_r + 1'b1;

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [BANK_W-1:0] rel;
    logic [ROW_W-1:0]  rrow;
    logic              we;
    logic [BIDX_W-1:0] waddr;
    row_word_t         wdata;

    always_comb begin
      rel  = BANK_W'(b) - cur_row_r[BANK_W-1:0];
      rrow = (rel == 2'd1) ? row_p1 : (rel == 2'd3) ? row_m1 : cur_row_r;
      if (!clear_done_r) begin
        we    = 1'b1;
        waddr = clr_cnt_r;
        wdata = '0;
        if ((b == START_ROW % BANKS) && (clr_cnt_r == BIDX_W'(START_ROW / BANKS))) begin
          wdata[START_COL] = 1'b1;
        end
      end else begin
        we    = commit && dec.push && (dec.row[BANK_W-1:0] == BANK_W'(b));
        waddr = dec.row[ROW_W-1:BANK_W];
        wdata = dec.wr_word;
      end
    end

    gdme_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (BANK_ROWS)
    ) u_vis (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (rrow[ROW_W-1:BANK_W]),
      .rdata (bank_rd[b])
    );
  end

  // return stack, top entry read continuously
  gdme_ram #(
    .WIDTH (ROW_W + COL_W),
    .DEPTH (CELLS)
  ) u_stack (
    .clk   (clk),
    .we    (commit && dec.push),
    .waddr (sp_r[CELL_W-1:0]),
    .wdata ({cur_row_r, cur_col_r}),
    .raddr (CELL_W'(sp_r - 1'b1)),
    .rdata (stk_rd)
  );

  // lanes
  always_comb begin
    lane_dir[0]  = DIR_UP;
    lane_dir[1]  = DIR_RIGHT;
    lane_dir[2]  = DIR_DOWN;
    lane_dir[3]  = DIR_LEFT;
    lane_read[0] = rd_up_r;
    lane_read[1] = rd_right_r;
    lane_read[2] = rd_down_r;
    lane_read[3] = rd_left_r;
    lane_word[0] = bank_rd[row_m1[BANK_W-1:0]];
    lane_word[1] = bank_rd[cur_row_r[BANK_W-1:0]];
    lane_word[2] = bank_rd[row_p1[BANK_W-1:0]];
    lane_word[3] = bank_rd[cur_row_r[BANK_W-1:0]];
  end

  for (genvar k = 0; k < DIRS; k++) begin : g_lane
    gdme_lane u_lane (
      .dir      (lane_dir[k]),
      .reading  (lane_read[k]),
      .cur_row  (cur_row_r),
      .cur_col  (cur_col_r),
      .eff_h    (eff_h),
      .eff_w    (eff_w),
      .row_word (lane_word[k]),
      .res      (lane_res[k])
    );
  end

  gdme_merge u_merge (
    .lane_res  (lane_res),
    .stack_ok  (sp_r != SP_W'(CELLS)),
    .stack_any (sp_r != '0),
    .cur_row   (cur_row_r),
    .cur_col   (cur_col_r),
    .pop_row   (stk_rd[ROW_W+COL_W-1:COL_W]),
    .pop_col   (stk_rd[COL_W-1:0]),
    .dec       (dec)
  );

  // position and stack pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= ROW_W'(START_ROW);
      cur_col_r <= COL_W'(START_COL);
      sp_r      <= '0;
    end else if (commit) begin
      cur_row_r <= dec.row;
      cur_col_r <= dec.col;
      if (dec.push) begin
        sp_r <= sp_r + 1'b1;
      end else if (dec.pop) begin
        sp_r <= sp_r - 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_move_r <= dec.has_move;
      out_dir_r  <= dec.dir;
      out_back_r <= dec.back;
      out_row_r  <= dec.row;
      out_col_r  <= dec.col;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.has_move     = out_move_r;
  assign out_ch.direction    = out_dir_r;
  assign out_ch.is_backtrack = out_back_r;
  assign out_ch.pos_row      = out_row_r;
  assign out_ch.pos_col      = out_col_r;

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(CELLS))
    else $error("return stack pointer beyond capacity");

  a_push_step: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && dec.push) |=> (sp_r == SP_W'($past(sp_r) + 1'b1)))
    else $error("push did not advance stack pointer");

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !clear_done_r |-> (!busy_r && !out_valid_r))
    else $error("step in flight during clearing pass");

endmodule

/* verif/grid_dfs_maze_explorer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_dfs_maze_explorer_tb
// Self-checking bench for the maze explorer. Sensor words are pushed through
// the step channel with random gaps and random back-pressure on the move
// channel. A behavioural copy of the explorer predicts every move word. The
// grid size is swept between phases, including out-of-range register values.
// ----------------------------------------------------------------------------
module grid_dfs_maze_explorer_tb;
  import gdme_pkg::*;

  typedef struct packed {
    logic [READ_W-1:0] up;
    logic [READ_W-1:0] down;
    logic [READ_W-1:0] left;
    logic [READ_W-1:0] right;
  } sense_t;

  typedef struct packed {
    logic             has_move;
    logic [DIR_W-1:0] direction;
    logic             is_backtrack;
    logic [ROW_W-1:0] pos_row;
    logic [COL_W-1:0] pos_col;
  } move_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_wdata;

  gdme_in_if  in_ch ();
  gdme_out_if out_ch ();

  grid_dfs_maze_explorer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // explorer copy
  logic [DIM_W-1:0] cols_cfg = DIM_RESET;
  logic [DIM_W-1:0] rows_cfg = DIM_RESET;
  bit               wall_seen [CELLS];
  bit               visited [CELLS];
  int               trail_row [CELLS];
  int               trail_col [CELLS];
  int               trail_depth = 0;
  int               at_row = START_ROW;
  int               at_col = START_COL;

  sense_t pending_steps [$];
  move_t  expected_moves [$];
  sense_t next_step;
  move_t  want;
  move_t  got;
  int     mismatches = 0;
  int     steps_queued = 0;
  int     steps_accepted = 0;
  int     in_gap = 0;
  int     rx_gap = 0;
  bit     step_took = 1'b0;
  bit     rx_hold = 1'b0;
  bit     calm = 1'b0;

  always #1 clk = ~clk;

  function automatic int span(logic [DIM_W-1:0] v, int top);
    if (v < DIM_MIN) return int'(DIM_MIN);
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  function automatic bit on_grid(int r, int c);
    return r >= 0 && r < span(rows_cfg, MAX_ROWS) && c >= 0 && c < span(cols_cfg, MAX_COLS);
  endfunction

  function automatic move_t explore_step(sense_t s);
    int               k;
    int               r;
    int               c;
    logic [READ_W-1:0] b;
    logic [DIR_W-1:0] d;
    move_t            m;
    m = '0;
    // record walls, sensor order up, down, left, right
    for (k = 0; k < 4; k++) begin
      r = at_row;
      c = at_col;
      case (k)
        0: begin r = at_row - 1; b = s.up; end
        1: begin r = at_row + 1; b = s.down; end
        2: begin c = at_col - 1; b = s.left; end
        default: begin c = at_col + 1; b = s.right; end
      endcase
      if (on_grid(r, c)) wall_seen[r * MAX_COLS + c] = (b == WALL_CHAR);
    end
    // advance: try up, right, down, left
    if (trail_depth < CELLS) begin
      for (k = 0; k < DIRS && !m.has_move; k++) begin
        d = k[DIR_W-1:0];
        r = at_row;
        c = at_col;
        case (d)
          DIR_UP:    r = at_row - 1;
          DIR_RIGHT: c = at_col + 1;
          DIR_DOWN:  r = at_row + 1;
          default:   c = at_col - 1;
        endcase
        if (on_grid(r, c) && !wall_seen[r * MAX_COLS + c] && !visited[r * MAX_COLS + c]) begin
          trail_row[trail_depth] = at_row;
          trail_col[trail_depth] = at_col;
          trail_depth++;
          visited[r * MAX_COLS + c] = 1'b1;
          at_row = r;
          at_col = c;
          m.has_move = 1'b1;
          m.direction = d;
        end
      end
    end
    // backtrack to the stacked cell
    if (!m.has_move && trail_depth > 0) begin
      trail_depth--;
      r = trail_row[trail_depth];
      c = trail_col[trail_depth];
      if (r == at_row - 1) m.direction = DIR_UP;
      else if (r == at_row + 1) m.direction = DIR_DOWN;
      else if (c == at_col - 1) m.direction = DIR_LEFT;
      else m.direction = DIR_RIGHT;
      at_row = r;
      at_col = c;
      m.has_move = 1'b1;
      m.is_backtrack = 1'b1;
    end
    m.pos_row = at_row[ROW_W-1:0];
    m.pos_col = at_col[COL_W-1:0];
    return m;
  endfunction

  function automatic int gap_len();
    int pick;
    if (calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [READ_W-1:0] sensed(int wall_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < wall_pct) return WALL_CHAR;
    if (pick < wall_pct + 10) return WALL_CHAR ^ (8'h01 << $urandom_range(0, 7));
    return READ_W'($urandom_range(0, 255));
  endfunction

  task automatic queue_step(sense_t s);
    pending_steps.insert(pending_steps.size(), s);
    steps_queued++;
  endtask

  task automatic load_random(int count, int wall_pct);
    sense_t s;
    repeat (count) begin
      s.up = sensed(wall_pct);
      s.down = sensed(wall_pct);
      s.left = sensed(wall_pct);
      s.right = sensed(wall_pct);
      queue_step(s);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GRID_WIDTH) cols_cfg = val;
    else rows_cfg = val;
    @(negedge clk);
  endtask

  task automatic set_grid(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    write_reg(CFG_GRID_WIDTH, w);
    write_reg(CFG_GRID_HEIGHT, h);
  endtask

  task automatic drain();
    while (steps_accepted != steps_queued || expected_moves.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // step driver: hold the word until taken, then idle for the drawn gap
  always @(negedge clk) begin
    if (!(in_ch.valid && !step_took)) begin
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap--;
      end else if (pending_steps.size() > 0) begin
        next_step = pending_steps.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.reading_up <= next_step.up;
        in_ch.reading_down <= next_step.down;
        in_ch.reading_left <= next_step.left;
        in_ch.reading_right <= next_step.right;
        in_gap = gap_len();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold) begin
      out_ch.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      out_ch.ready <= 1'b0;
      rx_gap--;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rx_gap = gap_len();
    end
  end

  always @(posedge clk) begin
    step_took = rst_n && in_ch.valid && in_ch.ready;
    if (step_took) begin
      expected_moves.insert(expected_moves.size(),
                            explore_step({in_ch.reading_up, in_ch.reading_down,
                                          in_ch.reading_left, in_ch.reading_right}));
      steps_accepted++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.has_move, out_ch.direction, out_ch.is_backtrack,
             out_ch.pos_row, out_ch.pos_col};
      if (expected_moves.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected move word: has_move=%0d dir=%0d back=%0d pos=(%0d,%0d)",
                   got.has_move, got.direction, got.is_backtrack, got.pos_row, got.pos_col);
      end else begin
        want = expected_moves.pop_front();
        if (got.has_move !== want.has_move || got.direction !== want.direction ||
            got.is_backtrack !== want.is_backtrack || got.pos_row !== want.pos_row ||
            got.pos_col !== want.pos_col) begin
          mismatches++;
          if (mismatches <= 10)
            $display("move mismatch: expected %0d/%0d/%0d (%0d,%0d) got %0d/%0d/%0d (%0d,%0d)",
                     want.has_move, want.direction, want.is_backtrack, want.pos_row,
                     want.pos_col, got.has_move, got.direction, got.is_backtrack,
                     got.pos_row, got.pos_col);
        end
      end
    end
  end

  // long receiver hold-off so the explorer backs up into the step channel
  initial begin
    while (steps_accepted < 620) @(negedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(negedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.reading_up = '0;
    in_ch.reading_down = '0;
    in_ch.reading_left = '0;
    in_ch.reading_right = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_GRID_WIDTH;
    cfg_wdata = '0;
    visited[START_ROW * MAX_COLS + START_COL] = 1'b1;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // boxed in at the start cell, then open moves, backtracks and a full unwind
    queue_step({WALL_CHAR, WALL_CHAR, WALL_CHAR, WALL_CHAR});
    queue_step({8'h00, 8'h00, 8'h00, 8'h00});
    queue_step({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    queue_step({8'h63, WALL_CHAR, 8'h42, WALL_CHAR});
    queue_step({8'h3F, 8'h3F, 8'h3F, 8'h3F});
    queue_step({WALL_CHAR, 8'hE2, 8'h00, 8'h22});
    queue_step({WALL_CHAR, WALL_CHAR, WALL_CHAR, WALL_CHAR});
    queue_step({8'h61, 8'h60, 8'h62, 8'hFF});
    repeat (5) queue_step({WALL_CHAR, WALL_CHAR, WALL_CHAR, WALL_CHAR});
    repeat (5) queue_step({8'h00, 8'hFF, 8'h3F, 8'h00});
    repeat (7) queue_step({WALL_CHAR, WALL_CHAR, WALL_CHAR, WALL_CHAR});
    drain();

    set_grid(6'd0, 6'd1);
    load_random(40, 20);
    drain();
    set_grid(DIM_MIN, DIM_MIN);
    load_random(30, 10);
    drain();
    set_grid(6'd63, 6'd63);
    load_random(300, 25);
    drain();
    set_grid(6'd33, DIM_MIN);
    load_random(100, 15);
    drain();
    set_grid(6'd1, 6'd40);
    load_random(100, 15);
    drain();
    set_grid(DIM_RESET, DIM_RESET);
    load_random(300, 35);
    drain();
    repeat (5) begin
      calm = $urandom_range(0, 1);
      set_grid(DIM_W'($urandom_range(0, 63)), DIM_W'($urandom_range(0, 63)));
      load_random(60, $urandom_range(5, 45));
      drain();
    end
    calm = 1'b0;
    repeat (10) @(negedge clk);

    if (mismatches == 0 && expected_moves.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
